FILE: rtl/cstb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstb_pkg
// Shared constants, payload types and fixed-point helpers for the clone-stamp
// texel blend pipeline (unsigned Q1.FRAC_BITS arithmetic).
// ----------------------------------------------------------------------------
package cstb_pkg;

   // fixed-point format
   localparam int FRAC_BITS = 15;
   localparam int FIELD_W   = 16;
   localparam int ONE_W     = FRAC_BITS + 1;
   localparam int VAL_W     = (ONE_W > FIELD_W) ? ONE_W : FIELD_W;

   // product and sum widths
   localparam int WH_W   = FIELD_W + ONE_W;
   localparam int PROD_W = FIELD_W + ONE_W;
   localparam int LT_W   = 2 * FIELD_W;
   localparam int SUM_W  = ((PROD_W > LT_W) ? PROD_W : LT_W) + 2;

   // divider default: quotient bits resolved per pipeline stage
   localparam int DIV_STEPS_DEFAULT = 4;

   // stream payload layout
   localparam int IN_FIELDS  = 11;
   localparam int OUT_FIELDS = 6;
   localparam int REQ_W      = ((IN_FIELDS * FIELD_W + 7) / 8) * 8;
   localparam int RSP_W      = ((OUT_FIELDS * FIELD_W + 7) / 8) * 8;

   // input field slots
   localparam int F_DST    = 0;
   localparam int F_SRC    = 4;
   localparam int F_PRIOR  = 8;
   localparam int F_WEIGHT = 9;
   localparam int F_CEIL   = 10;

   // channel slots within a texel, and output field slots
   localparam int CH_ALPHA = 3;
   localparam int O_STROKE = 4;
   localparam int O_COVER  = 5;

   localparam logic [ONE_W-1:0]     FX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [FRAC_BITS-1:0] FX_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic [FIELD_W-1:0]   FX_LIMIT =
      (ONE_W > FIELD_W) ? {FIELD_W{1'b1}} : FIELD_W'(FX_ONE);

   typedef logic [FIELD_W-1:0] field_type;

   // texel payload that rides along the pipeline
   typedef struct packed {
      field_type [3:0]  dst;
      field_type [3:0]  src;
      field_type        prior;
      logic [ONE_W-1:0] a1;
      logic             refuse;
   } carry_type;

   // one divider stage: partial remainder, remaining numerator bits, quotient, divisor, payload
   typedef struct packed {
      logic [ONE_W-1:0] rem;
      logic [ONE_W-1:0] num;
      logic [ONE_W-1:0] quot;
      logic [ONE_W-1:0] head;
      carry_type        carry;
   } div_stage_type;

   // min(v, ONE)
   function automatic logic [ONE_W-1:0] clamp_one(input field_type v);
      logic [VAL_W-1:0] x;
      x = VAL_W'(v);
      if (x > VAL_W'(FX_ONE)) begin
         return FX_ONE;
      end
      return x[ONE_W-1:0];
   endfunction

   // round to nearest, halves up, then drop the fraction
   function automatic logic [SUM_W-1:0] round_fx(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] t;
      t = v + SUM_W'(FX_HALF);
      return t >> FRAC_BITS;
   endfunction

   // saturate to the largest legal field value
   function automatic field_type sat_field(input logic [SUM_W-1:0] v);
      if (v > SUM_W'(FX_LIMIT)) begin
         return FX_LIMIT;
      end
      return v[FIELD_W-1:0];
   endfunction

endpackage

FILE: rtl/cstb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstb_front
// Two-stage front end: clamps, refusal decision and w*(1-a0) product, then
// the new stroke alpha and the divider operands for the coverage quotient.
// ----------------------------------------------------------------------------
module cstb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [cstb_pkg::REQ_W-1:0]    in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cstb_pkg::div_stage_type       out_data
);

   localparam int FW = cstb_pkg::FIELD_W;
   localparam int OW = cstb_pkg::ONE_W;
   localparam int SW = cstb_pkg::SUM_W;
   localparam int WW = cstb_pkg::WH_W;

   cstb_pkg::field_type     fld [cstb_pkg::IN_FIELDS];
   logic [OW-1:0]           a0_in;
   logic [OW-1:0]           cap_in;
   logic [OW-1:0]           head_in;
   logic [WW-1:0]           wh_in;
   logic                    src_zero;
   cstb_pkg::carry_type     carry_in;

   logic                    s1_vld_ff;
   logic [OW-1:0]           a0_ff;
   logic [OW-1:0]           cap_ff;
   logic [OW-1:0]           head_ff;
   logic [WW-1:0]           wh_ff;
   cstb_pkg::carry_type     s1_carry_ff;

   logic                    s2_vld_ff;
   cstb_pkg::div_stage_type s2_ff;
   cstb_pkg::div_stage_type s2_in;
   logic [SW-1:0]           inc;
   logic [SW-1:0]           total;
   logic [OW-1:0]           a1;
   logic [OW-1:0]           delta;

   logic                    ld1;
   logic                    ld2;

   // stage advance: a stage loads when empty or when the next one loads
   assign ld2      = !s2_vld_ff || out_ready;
   assign ld1      = !s1_vld_ff || ld2;
   assign in_ready = ld1;

   // stage 1: unpack, clamp, refusal, weight product
   always_comb begin
      for (int k = 0; k < cstb_pkg::IN_FIELDS; k++) begin
         fld[k] = in_data[k*FW +: FW];
      end
      a0_in    = cstb_pkg::clamp_one(fld[cstb_pkg::F_PRIOR]);
      cap_in   = cstb_pkg::clamp_one(fld[cstb_pkg::F_CEIL]);
      head_in  = cstb_pkg::FX_ONE - a0_in;
      wh_in    = WW'(fld[cstb_pkg::F_WEIGHT]) * WW'(head_in);
      src_zero = (fld[cstb_pkg::F_SRC] | fld[cstb_pkg::F_SRC+1] |
                  fld[cstb_pkg::F_SRC+2] | fld[cstb_pkg::F_SRC+3]) == '0;
      for (int c = 0; c < 4; c++) begin
         carry_in.dst[c] = fld[cstb_pkg::F_DST + c];
         carry_in.src[c] = fld[cstb_pkg::F_SRC + c];
      end
      carry_in.prior  = fld[cstb_pkg::F_PRIOR];
      carry_in.a1     = '0;
      carry_in.refuse = (fld[cstb_pkg::F_WEIGHT] == '0) || (cap_in == '0) ||
                        (head_in == '0) || (a0_in >= cap_in) || src_zero;
   end

   // stage 2: new stroke alpha, divider seed for (a1-a0)*ONE + head/2
   always_comb begin
      inc   = cstb_pkg::round_fx(SW'(wh_ff));
      total = inc + SW'(a0_ff);
      a1    = (total > SW'(cap_ff)) ? cap_ff : total[OW-1:0];
      delta = a1 - a0_ff;
      s2_in.rem        = OW'(delta[OW-1:1]);
      s2_in.num        = {delta[0], head_ff[OW-1:1]};
      s2_in.quot       = '0;
      s2_in.head       = head_ff;
      s2_in.carry      = s1_carry_ff;
      s2_in.carry.a1   = a1;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (ld1) begin
            s1_vld_ff <= in_valid;
         end
         if (ld2) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ld1) begin
         a0_ff       <= a0_in;
         cap_ff      <= cap_in;
         head_ff     <= head_in;
         wh_ff       <= wh_in;
         s1_carry_ff <= carry_in;
      end
      if (ld2) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_data  = s2_ff;

endmodule

FILE: rtl/cstb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstb_div
// Pipelined restoring divider for the coverage quotient. Each stage resolves
// STEPS quotient bits; ONE_W bits in total.
// ----------------------------------------------------------------------------
module cstb_div #(
   parameter int STEPS = cstb_pkg::DIV_STEPS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cstb_pkg::div_stage_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cstb_pkg::div_stage_type out_data
);

   localparam int OW     = cstb_pkg::ONE_W;
   localparam int STAGES = (OW + STEPS - 1) / STEPS;

   cstb_pkg::div_stage_type stg_ff  [STAGES];
   cstb_pkg::div_stage_type stg_in  [STAGES];
   cstb_pkg::div_stage_type prev    [STAGES];
   logic [STAGES-1:0]       vld_ff;
   logic [STAGES:0]         prev_vld;
   logic [STAGES-1:0]       ld;

   // stall chain from the output back to the input
   always_comb begin
      ld[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         ld[s] = !vld_ff[s] || ld[s+1];
      end
   end

   assign in_ready = ld[0];
   assign prev_vld = {vld_ff, in_valid};

   // restoring steps: shift in one numerator bit, subtract head if it fits
   always_comb begin
      logic [OW:0] trial;
      logic [OW:0] diff;
      trial   = '0;
      diff    = '0;
      prev[0] = in_data;
      for (int s = 1; s < STAGES; s++) begin
         prev[s] = stg_ff[s-1];
      end
      for (int s = 0; s < STAGES; s++) begin
         stg_in[s] = prev[s];
         for (int k = 0; k < STEPS; k++) begin
            if (s * STEPS + k < OW) begin
               trial = {stg_in[s].rem, stg_in[s].num[OW-1]};
               diff  = trial - {1'b0, stg_in[s].head};
               stg_in[s].num = stg_in[s].num << 1;
               if (trial >= {1'b0, stg_in[s].head}) begin
                  stg_in[s].rem  = diff[OW-1:0];
                  stg_in[s].quot = {stg_in[s].quot[OW-2:0], 1'b1};
               end else begin
                  stg_in[s].rem  = trial[OW-1:0];
                  stg_in[s].quot = {stg_in[s].quot[OW-2:0], 1'b0};
               end
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (ld[s]) begin
               vld_ff[s] <= prev_vld[s];
            end
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (ld[s]) begin
            stg_ff[s] <= stg_in[s];
         end
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_data  = stg_ff[STAGES-1];

endmodule

FILE: rtl/cstb_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstb_blend
// Four-stage blend back end: source times coverage, keep factor, destination
// and alpha-lock products, then round, saturate and select the result. The
// last stage is the result register of the block.
// ----------------------------------------------------------------------------
module cstb_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          alpha_locked,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cstb_pkg::div_stage_type       in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [cstb_pkg::RSP_W-1:0]    out_data
);

   localparam int FW = cstb_pkg::FIELD_W;
   localparam int OW = cstb_pkg::ONE_W;
   localparam int PW = cstb_pkg::PROD_W;
   localparam int LW = cstb_pkg::LT_W;
   localparam int SW = cstb_pkg::SUM_W;
   localparam int CA = cstb_pkg::CH_ALPHA;

   logic [3:0]          vld_ff;
   logic [3:0]          ld;

   // stage 1
   logic [PW-1:0]       p_in   [4];
   logic [PW-1:0]       p1_ff  [4];
   logic [OW-1:0]       a1_cov_ff;
   cstb_pkg::carry_type c1_ff;

   // stage 2
   logic [SW-1:0]       rp     [4];
   logic [SW-1:0]       sa;
   logic [OW-1:0]       keep_in;
   logic [OW-1:0]       keep_ff;
   cstb_pkg::field_type t2_ff  [3];
   logic [PW-1:0]       p2_ff  [4];
   logic [OW-1:0]       a2_cov_ff;
   cstb_pkg::carry_type c2_ff;

   // stage 3
   logic [PW-1:0]       dk3_ff [4];
   logic [LW-1:0]       lt3_ff [3];
   logic [PW-1:0]       p3_ff  [4];
   logic [OW-1:0]       a3_cov_ff;
   cstb_pkg::carry_type c3_ff;

   // stage 4 (result register)
   logic [SW-1:0]       total  [4];
   cstb_pkg::field_type res    [cstb_pkg::OUT_FIELDS];
   logic [cstb_pkg::RSP_W-1:0] out_in;
   logic [cstb_pkg::RSP_W-1:0] out_ff;

   // stall chain
   always_comb begin
      ld[3] = !vld_ff[3] || out_ready;
      for (int s = 2; s >= 0; s--) begin
         ld[s] = !vld_ff[s] || ld[s+1];
      end
   end

   assign in_ready = ld[0];

   // stage 1: source channels times coverage
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         p_in[c] = PW'(in_data.carry.src[c]) * PW'(in_data.quot);
      end
   end

   // stage 2: rounded source terms and keep = 1 - src_alpha*a, floored at 0
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         rp[c] = cstb_pkg::round_fx(SW'(p1_ff[c]));
      end
      sa      = rp[CA];
      keep_in = (sa >= SW'(cstb_pkg::FX_ONE)) ? '0 : cstb_pkg::FX_ONE - sa[OW-1:0];
   end

   // stage 4: sum, round, saturate; refusal passes the texel through
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (alpha_locked && c != CA) begin
            total[c] = SW'(dk3_ff[c]) + SW'(lt3_ff[c]);
         end else begin
            total[c] = SW'(p3_ff[c]) + SW'(dk3_ff[c]);
         end
         res[c] = cstb_pkg::sat_field(cstb_pkg::round_fx(total[c]));
      end
      if (alpha_locked) begin
         res[CA] = c3_ff.dst[CA];
      end
      res[cstb_pkg::O_STROKE] = cstb_pkg::sat_field(SW'(c3_ff.a1));
      res[cstb_pkg::O_COVER]  = cstb_pkg::sat_field(SW'(a3_cov_ff));
      if (c3_ff.refuse) begin
         for (int c = 0; c < 4; c++) begin
            res[c] = c3_ff.dst[c];
         end
         res[cstb_pkg::O_STROKE] = c3_ff.prior;
         res[cstb_pkg::O_COVER]  = '0;
      end
      out_in = '0;
      for (int k = 0; k < cstb_pkg::OUT_FIELDS; k++) begin
         out_in[k*FW +: FW] = res[k];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (ld[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int s = 1; s < 4; s++) begin
            if (ld[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ld[0]) begin
         p1_ff     <= p_in;
         a1_cov_ff <= in_data.quot;
         c1_ff     <= in_data.carry;
      end
      if (ld[1]) begin
         keep_ff   <= keep_in;
         for (int c = 0; c < 3; c++) begin
            t2_ff[c] <= rp[c][FW-1:0];
         end
         p2_ff     <= p1_ff;
         a2_cov_ff <= a1_cov_ff;
         c2_ff     <= c1_ff;
      end
      if (ld[2]) begin
         for (int c = 0; c < 4; c++) begin
            dk3_ff[c] <= PW'(c2_ff.dst[c]) * PW'(keep_ff);
         end
         for (int c = 0; c < 3; c++) begin
            lt3_ff[c] <= LW'(t2_ff[c]) * LW'(c2_ff.dst[CA]);
         end
         p3_ff     <= p2_ff;
         a3_cov_ff <= a2_cov_ff;
         c3_ff     <= c2_ff;
      end
      if (ld[3]) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_data  = out_ff;

endmodule

FILE: rtl/clone_stamp_texel_blend_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clone_stamp_texel_blend_top
// Clone-stamp texel composite: premultiplied source-over (or color-only with
// alpha lock) with stroke alpha accumulation and opacity ceiling, Q1.15.
//
//   channel  direction  handshake                 payload
//   req_     in         req_tvalid / req_tready   req_tdata, 11 x 16 bits
//   rsp_     out        rsp_tvalid / rsp_tready   rsp_tdata, 6 x 16 bits
//   csr_     in         csr_wr_en                 csr_wr_data (alpha lock)
//
// One transaction per clock sustained while rsp_tready stays high; the depth
// of the pipelined coverage divider is set by DIV_STEPS.
// Every stage holds a valid bit; a full stage stalls only when the stage
// after it is full and stalled, so bubbles collapse.
// Synchronous active-high reset clears valid bits and the alpha lock.
// ----------------------------------------------------------------------------
module clone_stamp_texel_blend_top #(
   parameter int DIV_STEPS = cstb_pkg::DIV_STEPS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata, low bit up: dst_red, dst_green, dst_blue, dst_alpha,
   // src_red, src_green, src_blue, src_alpha, prior_stroke_alpha,
   // dab_weight, ceiling
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [cstb_pkg::REQ_W-1:0] req_tdata,
   // rsp_tdata, low bit up: out_red, out_green, out_blue, out_alpha,
   // new_stroke_alpha, applied_coverage
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [cstb_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);

   logic                    alpha_locked_ff;
   logic                    alpha_locked_in;

   logic                    fd_valid;
   logic                    fd_ready;
   cstb_pkg::div_stage_type fd_data;
   logic                    db_valid;
   logic                    db_ready;
   cstb_pkg::div_stage_type db_data;

   // alpha lock register
   assign alpha_locked_in = csr_wr_en ? csr_wr_data : alpha_locked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_locked_ff <= 1'b0;
      end else begin
         alpha_locked_ff <= alpha_locked_in;
      end
   end

   cstb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (fd_valid),
      .out_ready (fd_ready),
      .out_data  (fd_data)
   );

   cstb_div #(
      .STEPS (DIV_STEPS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fd_valid),
      .in_ready  (fd_ready),
      .in_data   (fd_data),
      .out_valid (db_valid),
      .out_ready (db_ready),
      .out_data  (db_data)
   );

   cstb_blend u_blend (
      .clock        (clock),
      .reset        (reset),
      .alpha_locked (alpha_locked_ff),
      .in_valid     (db_valid),
      .in_ready     (db_ready),
      .in_data      (db_data),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (rsp_tdata)
   );

endmodule

FILE: rtl/cstb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstb_checker
// Port-level checks for the clone-stamp texel blend: result hold under
// stall, reset behavior, flow control and the coverage range.
// ----------------------------------------------------------------------------
module cstb_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [cstb_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int FW = cstb_pkg::FIELD_W;
   localparam int CO = cstb_pkg::O_COVER * cstb_pkg::FIELD_W;

   // a stalled result stays put
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // with the result register free, the pipeline takes a transaction
   a_ready_flow : assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled with free result register");

   // coverage never exceeds 1.0
   a_cover_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[CO +: FW] <= cstb_pkg::FX_LIMIT)
      else $error("coverage above 1.0");

   // request valid is only observed here, for trace context
   logic req_seen;
   assign req_seen = req_tvalid && req_tready;

   a_req_known : assert property (@(posedge clock) disable iff (reset)
      req_seen |-> req_tready)
      else $error("accept without ready");

endmodule

bind clone_stamp_texel_blend_top cstb_checker u_cstb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clone-stamp texel blend. Drives texels over the
// req_ stream and writes the alpha lock over csr_. A local Q1.15 model
// predicts each composite, and every rsp_ transaction is checked field by
// field against the oldest prediction. Coverage comes from directed refusal
// and corner texels in both lock modes, then random texels: mostly well-formed
// strokes, loose controls, raw bit noise. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

   typedef cstb_pkg::field_type field_type;

   localparam int FRAC_BITS  = cstb_pkg::FRAC_BITS;
   localparam int FIELD_W    = cstb_pkg::FIELD_W;
   localparam int IN_FIELDS  = cstb_pkg::IN_FIELDS;
   localparam int OUT_FIELDS = cstb_pkg::OUT_FIELDS;
   localparam int REQ_W      = cstb_pkg::REQ_W;
   localparam int RSP_W      = cstb_pkg::RSP_W;
   localparam int F_DST      = cstb_pkg::F_DST;
   localparam int F_SRC      = cstb_pkg::F_SRC;
   localparam int F_PRIOR    = cstb_pkg::F_PRIOR;
   localparam int F_WEIGHT   = cstb_pkg::F_WEIGHT;
   localparam int F_CEIL     = cstb_pkg::F_CEIL;
   localparam int CH_ALPHA   = cstb_pkg::CH_ALPHA;
   localparam int O_STROKE   = cstb_pkg::O_STROKE;
   localparam int O_COVER    = cstb_pkg::O_COVER;

   localparam longint unsigned UNITY   = 64'd1 << FRAC_BITS;
   localparam longint unsigned SAT_MAX = (UNITY < 64'hFFFF) ? UNITY : 64'hFFFF;
   localparam int unsigned     ONE_U   = 32'd1 << FRAC_BITS;
   localparam field_type       ONE16   = field_type'(UNITY);
   localparam field_type       FULL16  = {FIELD_W{1'b1}};
   localparam int              LIMIT_CYCLES = 500_000;
   localparam int              SETTLE_CYCLES = 32;

   typedef field_type [IN_FIELDS-1:0]  texel_req_type;
   typedef field_type [OUT_FIELDS-1:0] texel_rsp_type;

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_wr_en   = 1'b0;
   logic             csr_wr_data = 1'b0;

   texel_rsp_type expected_composites[$];
   bit         lock_shadow   = 1'b0;
   bit         steady_source = 1'b0;
   bit         steady_sink   = 1'b0;
   int         result_errors = 0;
   int         sink_hold     = 0;
   int         cycle_count   = 0;
   string      rsp_field_name [OUT_FIELDS] = '{"out_red", "out_green", "out_blue",
      "out_alpha", "new_stroke_alpha", "applied_coverage"};

   clone_stamp_texel_blend_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Fixed-point helpers and composite predictor
   // ------------------------------------------------------------------
   function automatic longint unsigned fx_round(longint unsigned v);
      return (v + (UNITY >> 1)) >> FRAC_BITS;
   endfunction

   function automatic field_type fx_sat(longint unsigned v);
      return field_type'((v > SAT_MAX) ? SAT_MAX : v);
   endfunction

   function automatic texel_rsp_type composite_texel(texel_req_type t, bit locked);
      texel_rsp_type   o;
      longint unsigned cap, a0, head, a1, cov, sa, keep, tint;
      for (int c = 0; c < 4; c++) o[c] = t[F_DST + c];
      o[O_STROKE] = t[F_PRIOR];
      o[O_COVER]  = '0;
      cap  = (t[F_CEIL] > UNITY) ? UNITY : longint'(t[F_CEIL]);
      a0   = (t[F_PRIOR] > UNITY) ? UNITY : longint'(t[F_PRIOR]);
      head = UNITY - a0;
      // dab refused: texel passes through untouched
      if (t[F_WEIGHT] == 0 || cap == 0 || head == 0 || a0 >= cap) return o;
      if ((t[F_SRC] | t[F_SRC + 1] | t[F_SRC + 2] | t[F_SRC + CH_ALPHA]) == 0) return o;
      // stroke alpha growth, capped by the ceiling
      a1 = a0 + fx_round(longint'(t[F_WEIGHT]) * head);
      if (a1 > cap) a1 = cap;
      cov = ((a1 - a0) * UNITY + (head >> 1)) / head;
      if (cov > UNITY) cov = UNITY;
      sa   = fx_round(longint'(t[F_SRC + CH_ALPHA]) * cov);
      keep = (sa >= UNITY) ? 0 : UNITY - sa;
      if (locked) begin
         // color only, destination alpha frozen
         for (int c = 0; c < 3; c++) begin
            tint = fx_round(longint'(t[F_SRC + c]) * cov);
            o[c] = fx_sat(fx_round(longint'(t[F_DST + c]) * keep +
                                   tint * longint'(t[F_DST + CH_ALPHA])));
         end
         o[CH_ALPHA] = t[F_DST + CH_ALPHA];
      end else begin
         for (int c = 0; c < 4; c++)
            o[c] = fx_sat(fx_round(longint'(t[F_SRC + c]) * cov +
                                   longint'(t[F_DST + c]) * keep));
      end
      o[O_STROKE] = fx_sat(a1);
      o[O_COVER]  = fx_sat(cov);
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic texel_req_type texel(field_type dr, field_type dg, field_type db,
                                           field_type da, field_type sr, field_type sg,
                                           field_type sb, field_type sa, field_type prior,
                                           field_type weight, field_type ceiling);
      texel_req_type t;
      t[F_DST]     = dr;  t[F_DST + 1] = dg;  t[F_DST + 2] = db;  t[F_DST + CH_ALPHA] = da;
      t[F_SRC]     = sr;  t[F_SRC + 1] = sg;  t[F_SRC + 2] = sb;  t[F_SRC + CH_ALPHA] = sa;
      t[F_PRIOR]   = prior;
      t[F_WEIGHT]  = weight;
      t[F_CEIL]    = ceiling;
      return t;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // channel level biased toward the range edges
   function automatic field_type pick_level();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8)  return '0;
      if (r < 12) return field_type'(1);
      if (r < 16) return ONE16 - field_type'(1);
      if (r < 24) return ONE16;
      return field_type'($urandom_range(0, ONE_U));
   endfunction

   function automatic texel_req_type random_texel();
      texel_req_type t;
      int unsigned   r;
      r = $urandom_range(0, 99);
      // raw noise, every bit pattern possible
      if (r < 15) begin
         for (int i = 0; i < IN_FIELDS; i++) t[i] = field_type'($urandom);
         return t;
      end
      for (int i = 0; i < 8; i++) t[i] = pick_level();
      if (r < 27) begin
         // loosely formed stroke controls, many refusals
         t[F_PRIOR]  = pick_level();
         t[F_WEIGHT] = pick_level();
         t[F_CEIL]   = pick_level();
         return t;
      end
      // well-formed dab: prior below ceiling, nonzero weight
      t[F_PRIOR] = ($urandom_range(0, 3) == 0) ? '0 :
                   field_type'($urandom_range(0, ONE_U - 1));
      case ($urandom_range(0, 9))
         0:       t[F_WEIGHT] = field_type'($urandom_range(1, 3));
         1:       t[F_WEIGHT] = ONE16;
         default: t[F_WEIGHT] = field_type'($urandom_range(1, ONE_U));
      endcase
      if ($urandom_range(0, 9) == 0) t[F_CEIL] = field_type'($urandom_range(ONE_U, 16'hFFFF));
      else t[F_CEIL] = field_type'($urandom_range(32'(t[F_PRIOR]) + 1, ONE_U));
      return t;
   endfunction

   // one req_ transaction, then a random gap
   task automatic send_texel(texel_req_type t);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(t);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_composites = {expected_composites, composite_texel(t, lock_shadow)};
      gap = steady_source ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and wait for every outstanding composite
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_composites.size() != 0);
   endtask

   task automatic write_lock(bit value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      lock_shadow = value;
   endtask

   task automatic run_in_both_modes(texel_req_type cases[$]);
      for (int m = 0; m < 2; m++) begin
         write_lock(m[0]);
         foreach (cases[k]) send_texel(cases[k]);
      end
   endtask

   // random texels; idle pattern reshuffled every 50 transactions
   task automatic run_texels(int count, int pause_at);
      for (int i = 0; i < count; i++) begin
         if (i > 0 && i % 50 == 0) begin
            steady_source = ($urandom_range(0, 3) == 0);
            steady_sink   = ($urandom_range(0, 3) == 0);
         end
         if (i == pause_at) drain_results();
         send_texel(random_texel());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_refusals();
      texel_req_type cases[$];
      // zero weight
      cases = {cases, texel(16'h2000, 16'h1000, 16'h0800, ONE16, 16'h1000, 16'h2000,
                            16'h3000, 16'h4000, 16'h0000, 16'h0000, ONE16)};
      // zero ceiling
      cases = {cases, texel(16'h2000, 16'h1000, 16'h0800, ONE16, 16'h1000, 16'h2000,
                            16'h3000, 16'h4000, 16'h0000, ONE16, 16'h0000)};
      // stroke alpha already full
      cases = {cases, texel(16'h1234, 16'h2345, 16'h3456, 16'h4567, ONE16, ONE16,
                            ONE16, ONE16, ONE16, ONE16, ONE16)};
      // stroke alpha above full, passed through as given
      cases = {cases, texel(16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'h1000, 16'h1000,
                            16'h1000, 16'h1000, FULL16, 16'h1234, FULL16)};
      // ceiling reached exactly
      cases = {cases, texel(16'h0100, 16'h0200, 16'h0300, 16'h4000, 16'h1000, 16'h1000,
                            16'h1000, 16'h2000, 16'h2000, ONE16, 16'h2000)};
      // ceiling exceeded
      cases = {cases, texel(16'h0100, 16'h0200, 16'h0300, 16'h4000, 16'h1000, 16'h1000,
                            16'h1000, 16'h2000, 16'h6000, ONE16, 16'h2000)};
      // empty source
      cases = {cases, texel(16'h3000, 16'h2000, 16'h1000, 16'h7000, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, ONE16, ONE16)};
      run_in_both_modes(cases);
   endtask

   task automatic test_blend_corners();
      texel_req_type cases[$];
      // opaque source, full coverage
      cases = {cases, texel(16'h1111, 16'h2222, 16'h3333, 16'h4444, ONE16, ONE16,
                            ONE16, ONE16, 16'h0000, ONE16, ONE16)};
      // weight too small to move stroke alpha
      cases = {cases, texel(16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h2000, 16'h3000,
                            16'h4000, 16'h5000, ONE16 - field_type'(1), 16'h0001, ONE16)};
      // ceiling clips the stroke alpha
      cases = {cases, texel(16'h0800, 16'h1800, 16'h2800, 16'h6000, 16'h3000, 16'h2000,
                            16'h1000, 16'h5000, 16'h1000, 16'h7000, 16'h3000)};
      // every field but the prior beyond range: outputs saturate
      cases = {cases, texel(FULL16, FULL16, FULL16, FULL16, FULL16, FULL16,
                            FULL16, FULL16, 16'h0000, FULL16, FULL16)};
      // alpha-only source
      cases = {cases, texel(16'h2000, 16'h3000, 16'h4000, 16'h5000, 16'h0000, 16'h0000,
                            16'h0000, ONE16, 16'h4000, 16'h4000, ONE16)};
      // red-only source on empty destination, smallest weight
      cases = {cases, texel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 16'h0001, ONE16)};
      run_in_both_modes(cases);
   endtask

   task automatic test_random_source_over();
      write_lock(1'b0);
      steady_source = 1'b0;
      steady_sink   = 1'b0;
      run_texels(200, -1);
   endtask

   // includes a pause until the pipeline is empty
   task automatic test_random_alpha_locked();
      write_lock(1'b1);
      steady_source = 1'b0;
      steady_sink   = 1'b0;
      run_texels(200, 100);
   endtask

   // first phase at full rate, then random idling
   task automatic test_lock_switching();
      steady_source = 1'b1;
      steady_sink   = 1'b1;
      for (int p = 0; p < 4; p++) begin
         write_lock(p[0] ^ 1'b1);
         run_texels(50, -1);
         steady_source = 1'b0;
         steady_sink   = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Result sink and checker
   // ------------------------------------------------------------------
   task automatic note_mismatch(string what);
      result_errors++;
      if (result_errors <= 10) $display("[%0t] mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin
      texel_rsp_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[OUT_FIELDS*FIELD_W-1:0];
            if (expected_composites.size() == 0) begin
               note_mismatch($sformatf("unexpected transaction %h", got));
            end else begin
               want = expected_composites.pop_front();
               for (int f = 0; f < OUT_FIELDS; f++)
                  if (got[f] !== want[f])
                     note_mismatch($sformatf("%s expected %h got %h",
                                             rsp_field_name[f], want[f], got[f]));
            end
         end
         // backpressure
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            sink_hold = steady_sink ? 0 : idle_length();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_refusals();
      test_blend_corners();
      test_random_source_over();
      test_random_alpha_locked();
      test_lock_switching();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (result_errors == 0 && expected_composites.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
